/* sv/psv_pkg.sv */
// Shared types, constants and lookup tables for the sine voice synthesizer.
`default_nettype none
package psv_pkg;

  localparam int MAX_VOICES      = 16;
  localparam int SINE_TABLE_BITS = 8;
  localparam int MAX_RESULTS     = 16;
  localparam int TABLE_LEN       = 1 << SINE_TABLE_BITS;
  localparam int CNT_W           = $clog2(MAX_VOICES + 1);
  localparam int IDX_W           = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int RES_W           = $clog2(MAX_RESULTS);
  localparam int SUM_W           = 18 + $clog2(MAX_VOICES);

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // input modes
  localparam logic [2:0] MODE_ON    = 3'd0;
  localparam logic [2:0] MODE_OFF   = 3'd1;
  localparam logic [2:0] MODE_CHOKE = 3'd2;
  localparam logic [2:0] MODE_TICK  = 3'd3;
  localparam logic [2:0] MODE_EOB   = 3'd4;

  // configuration register indexes
  localparam logic CFG_BASE_INC = 1'b0;
  localparam logic CFG_GAIN     = 1'b1;

  localparam logic [31:0] BASE_INC_RST = 32'd39370534;
  localparam logic [14:0] GAIN_RST     = 15'd6554;

  // result kinds
  localparam logic KIND_SAMPLE   = 1'b0;
  localparam logic KIND_NOTE_END = 1'b1;

  // voice cell commands
  localparam logic [1:0] CELL_KEEP = 2'd0;
  localparam logic [1:0] CELL_TAKE = 2'd1;
  localparam logic [1:0] CELL_LOAD = 2'd2;
  localparam logic [1:0] CELL_REL  = 2'd3;

  typedef struct packed {
    logic        held;
    logic [31:0] ident;
    logic [4:0]  chan;
    logic [7:0]  key;
    logic [31:0] phase;
  } voice_t;

  typedef struct packed {
    logic [7:0]  key;
    logic [31:0] ident;
    logic [4:0]  chan;
  } event_t;

  typedef logic [14:0] sine_tab_t [TABLE_LEN + 1];
  typedef logic [3:0]  semi_idx_t [256];
  typedef logic [5:0]  shift_tab_t [256];
  typedef logic [31:0] semi_tab_t [12];

  localparam semi_tab_t SEMI_Q31 = '{
    32'd2147483648, 32'd2275179671, 32'd2410468894, 32'd2553802834,
    32'd2705659851, 32'd2866546760, 32'd3037000500, 32'd3217589946,
    32'd3408917802, 32'd3611622603, 32'd3826380858, 32'd4053909304
  };

  // quarter-wave table, truncating Horner series in Q30
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i <= TABLE_LEN; i++) begin
      x  = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      tab[i] = v[14:0];
    end
    return tab;
  endfunction

  // semitone within the octave for each key code
  function automatic semi_idx_t build_semi_idx();
    semi_idx_t tab;
    int        key;
    int        d;
    for (int k = 0; k < 256; k++) begin
      key    = (k >= 128) ? k - 256 : k;
      d      = key - 57 + 192;
      tab[k] = 4'(d % 12);
    end
    return tab;
  endfunction

  // right shift minus one applied to base * semitone ratio
  function automatic shift_tab_t build_shift_tab();
    shift_tab_t tab;
    int         key;
    int         d;
    for (int k = 0; k < 256; k++) begin
      key    = (k >= 128) ? k - 256 : k;
      d      = key - 57 + 192;
      tab[k] = 6'(30 - (d / 12 - 16));
    end
    return tab;
  endfunction

  localparam sine_tab_t  SINE_TAB  = build_sine_tab();
  localparam semi_idx_t  KEY_SEMI  = build_semi_idx();
  localparam shift_tab_t KEY_SHIFT = build_shift_tab();

endpackage
`default_nettype wire

/* sv/psv_ifc.sv */
// Valid/ready channel interfaces for events in and results out.
`default_nettype none
interface psv_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  note_key;
  logic [31:0] note_ident;
  logic [4:0]  note_channel;
  modport source (output valid, mode, note_key, note_ident, note_channel, input ready);
  modport sink   (input valid, mode, note_key, note_ident, note_channel, output ready);
endinterface

interface psv_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [17:0] sample;
  logic [7:0]  end_key;
  logic [31:0] end_ident;
  logic [4:0]  end_channel;
  logic        last;
  modport source (output valid, kind, sample, end_key, end_ident, end_channel, last,
                  input ready);
  modport sink   (input valid, kind, sample, end_key, end_ident, end_channel, last,
                  output ready);
endinterface
`default_nettype wire

/* sv/psv_cell.sv */
// One voice slot of the voice chain: holds an entry and matches events.
`default_nettype none
module psv_cell (
  input  wire                   clk,
  input  wire  [1:0]            cmd,
  input  psv_pkg::voice_t       nbr,
  input  psv_pkg::voice_t       load,
  input  psv_pkg::event_t       ev,
  output psv_pkg::voice_t       q,
  output logic                  match
);
  psv_pkg::voice_t v_r;
  psv_pkg::voice_t v_nxt;

  always_comb begin
    v_nxt = v_r;
    case (cmd)
      psv_pkg::CELL_KEEP: v_nxt = v_r;
      psv_pkg::CELL_TAKE: v_nxt = nbr;
      psv_pkg::CELL_LOAD: v_nxt = load;
      psv_pkg::CELL_REL:  v_nxt.held = 1'b0;
      default:            v_nxt = v_r;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  // all-ones fields are wildcards
  assign match = (ev.key == 8'hFF || v_r.key == ev.key)
              && (ev.ident == 32'hFFFF_FFFF || v_r.ident == ev.ident)
              && (ev.chan == 5'h1F || v_r.chan == ev.chan);
  assign q = v_r;
endmodule
`default_nettype wire

/* sv/psv_tick_unit.sv */
// Shared per-voice arithmetic for a tick: phase increment and gained sine term.
`default_nettype none
module psv_tick_unit (
  input  wire                clk,
  input  wire                en_a,
  input  wire                en_b,
  input  wire  [31:0]        phase,
  input  wire  [7:0]         key,
  input  wire  [31:0]        base_inc,
  input  wire  [14:0]        gain,
  output logic [31:0]        inc,
  output logic signed [16:0] term
);
  localparam int SB = psv_pkg::SINE_TABLE_BITS;

  logic [63:0]        prod_r;
  logic [5:0]         shm1_r;
  logic signed [15:0] lk_r;
  logic [31:0]        inc_r;
  logic signed [31:0] gprod_r;

  logic [1:0]         quad;
  logic [SB-1:0]      frac;
  logic [SB:0]        tidx;
  logic [14:0]        tval;
  logic signed [15:0] lk_nxt;
  logic [63:0]        shifted;
  logic [32:0]        rnd;
  logic signed [31:0] tsum;

  always_comb begin
    quad   = phase[31:30];
    frac   = phase[29 -: SB];
    tidx   = quad[0] ? (SB+1)'(psv_pkg::TABLE_LEN) - {1'b0, frac} : {1'b0, frac};
    tval   = psv_pkg::SINE_TAB[tidx];
    lk_nxt = quad[1] ? -$signed({1'b0, tval}) : $signed({1'b0, tval});
  end

  always_comb begin
    shifted = prod_r >> shm1_r;
    rnd     = shifted[32:0] + 33'd1;
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      prod_r <= 64'(base_inc) * 64'(psv_pkg::SEMI_Q31[psv_pkg::KEY_SEMI[key]]);
      shm1_r <= psv_pkg::KEY_SHIFT[key];
      lk_r   <= lk_nxt;
    end
    if (en_b) begin
      inc_r   <= rnd[32:1];
      gprod_r <= lk_r * $signed({1'b0, gain});
    end
  end

  // floor((lookup * gain + 16384) / 32768)
  assign tsum = gprod_r + 32'sd16384;
  assign term = tsum[31:15];
  assign inc  = inc_r;
endmodule
`default_nettype wire

/* sv/polyphonic_sine_voice_synth.sv */
// Top level: voice chain, sequencer and result register of the sine voice synthesizer.
// Items are taken one at a time. Note on and note off update the chain in the ONOFF
// state. A choke removes the matching voices one at a time. A sample tick rotates the whole
// voice chain once through the shared increment/gain unit: an empty or released slot is
// only rotated, a held voice also passes states TK_B and TK_C, and the sum is then offered
// as a sample. End of block gives one note-end result per released voice, up to
// MAX_RESULTS, and ends at once when no voice is released. A tick or a note end also waits
// while the result register is still full. The result register lets the next item enter
// while a result waits to be taken.
`default_nettype none
module polyphonic_sine_voice_synth (
  input  wire        clk,
  input  wire        rst_n,
  psv_in_if.sink     in_ch,
  psv_out_if.source  out_ch,
  input  wire        cfg_we,
  input  wire        cfg_idx,
  input  wire [31:0] cfg_data
);
  localparam int N     = psv_pkg::MAX_VOICES;
  localparam int CNT_W = psv_pkg::CNT_W;
  localparam int IDX_W = psv_pkg::IDX_W;
  localparam int RES_W = psv_pkg::RES_W;
  localparam int SUM_W = psv_pkg::SUM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ONOFF = 3'd1;
  localparam logic [2:0] ST_CHOKE = 3'd2;
  localparam logic [2:0] ST_TK_A  = 3'd3;
  localparam logic [2:0] ST_TK_B  = 3'd4;
  localparam logic [2:0] ST_TK_C  = 3'd5;
  localparam logic [2:0] ST_TK_O  = 3'd6;
  localparam logic [2:0] ST_EOB   = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic [31:0]            base_r;
  logic [14:0]            gain_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [IDX_W-1:0]       rot_r, rot_nxt;
  logic [RES_W-1:0]       nres_r, nres_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [2:0]             mode_r;
  psv_pkg::event_t        ev_r;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_last_r;
  logic [17:0]            out_sample_r;
  logic [7:0]             out_key_r;
  logic [31:0]            out_ident_r;
  logic [4:0]             out_chan_r;

  psv_pkg::voice_t        cell_q [N];
  logic [N-1:0]           hit;
  logic [1:0]             cmd [N];
  psv_pkg::voice_t        load_v;
  psv_pkg::voice_t        rot_v;
  psv_pkg::voice_t        first_v;

  logic                   in_acc, out_free, load_out;
  logic                   tk_live, unit_a, unit_b;
  logic [31:0]            inc;
  logic signed [16:0]     term;
  logic [N-1:0]           live, sel, pre, first_oh;
  logic                   any_sel, second;
  logic                   nlast;
  logic signed [17:0]     sat_sample;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign load_v = '{held: 1'b1, ident: ev_r.ident, chan: ev_r.chan, key: ev_r.key,
                    phase: 32'd0};

  always_comb begin
    rot_v = cell_q[0];
    if (state_r == ST_TK_C) rot_v.phase = cell_q[0].phase + inc;
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      psv_pkg::voice_t nbr;
      if (g == N - 1) begin : g_tail
        assign nbr = rot_v;
      end else begin : g_mid
        assign nbr = cell_q[g+1];
      end
      psv_cell u_cell (
        .clk   (clk),
        .cmd   (cmd[g]),
        .nbr   (nbr),
        .load  (load_v),
        .ev    (ev_r),
        .q     (cell_q[g]),
        .match (hit[g])
      );
    end
  endgenerate

  assign tk_live = (CNT_W'(rot_r) < count_r) && cell_q[0].held;
  assign unit_a  = (state_r == ST_TK_A) && tk_live;
  assign unit_b  = (state_r == ST_TK_B);

  psv_tick_unit u_tick (
    .clk      (clk),
    .en_a     (unit_a),
    .en_b     (unit_b),
    .phase    (cell_q[0].phase),
    .key      (cell_q[0].key),
    .base_inc (base_r),
    .gain     (gain_r),
    .inc      (inc),
    .term     (term)
  );

  // candidate slots: matches for choke, released voices for end of block
  always_comb begin
    for (int j = 0; j < N; j++) begin
      live[j] = CNT_W'(j) < count_r;
      sel[j]  = live[j] && ((state_r == ST_EOB) ? !cell_q[j].held : hit[j]);
    end
    pre[0] = sel[0];
    for (int j = 1; j < N; j++) pre[j] = pre[j-1] | sel[j];
    first_oh[0] = sel[0];
    for (int j = 1; j < N; j++) first_oh[j] = sel[j] && !pre[j-1];
    any_sel = pre[N-1];
    second  = |(sel & ~first_oh);
    first_v = '0;
    for (int j = 0; j < N; j++) if (first_oh[j]) first_v = first_v | cell_q[j];
  end

  assign nlast = !second || (nres_r == RES_W'(psv_pkg::MAX_RESULTS - 1));

  always_comb begin
    if (sum_r > SUM_W'(131071))       sat_sample = 18'sd131071;
    else if (sum_r < -SUM_W'(131072)) sat_sample = -18'sd131072;
    else                              sat_sample = sum_r[17:0];
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rot_nxt   = rot_r;
    nres_nxt  = nres_r;
    sum_nxt   = sum_r;
    load_out  = 1'b0;
    for (int j = 0; j < N; j++) cmd[j] = psv_pkg::CELL_KEEP;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rot_nxt  = '0;
          nres_nxt = '0;
          sum_nxt  = '0;
          case (in_ch.mode)
            psv_pkg::MODE_ON, psv_pkg::MODE_OFF: state_nxt = ST_ONOFF;
            psv_pkg::MODE_CHOKE: state_nxt = ST_CHOKE;
            psv_pkg::MODE_TICK:  state_nxt = ST_TK_A;
            psv_pkg::MODE_EOB:   state_nxt = ST_EOB;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ONOFF: begin
        for (int j = 0; j < N; j++) begin
          if (mode_r == psv_pkg::MODE_ON && count_r < CNT_W'(N) && CNT_W'(j) == count_r)
            cmd[j] = psv_pkg::CELL_LOAD;
          else if (hit[j] && live[j])
            cmd[j] = psv_pkg::CELL_REL;
        end
        if (mode_r == psv_pkg::MODE_ON && count_r < CNT_W'(N)) count_nxt = count_r + 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CHOKE: begin
        if (any_sel) begin
          for (int j = 0; j < N; j++) if (pre[j]) cmd[j] = psv_pkg::CELL_TAKE;
          count_nxt = count_r - 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TK_A, ST_TK_C: begin
        if (state_r == ST_TK_A && tk_live) begin
          state_nxt = ST_TK_B;
        end else begin
          for (int j = 0; j < N; j++) cmd[j] = psv_pkg::CELL_TAKE;
          if (state_r == ST_TK_C) sum_nxt = sum_r + SUM_W'(term);
          if (rot_r == IDX_W'(N - 1)) begin
            state_nxt = ST_TK_O;
          end else begin
            rot_nxt   = rot_r + 1'b1;
            state_nxt = ST_TK_A;
          end
        end
      end
      ST_TK_B: state_nxt = ST_TK_C;
      ST_TK_O: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EOB: begin
        if (!any_sel) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          load_out = 1'b1;
          for (int j = 0; j < N; j++) if (pre[j]) cmd[j] = psv_pkg::CELL_TAKE;
          count_nxt = count_r - 1'b1;
          nres_nxt  = nres_r + 1'b1;
          if (nlast) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      base_r      <= psv_pkg::BASE_INC_RST;
      gain_r      <= psv_pkg::GAIN_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_idx == psv_pkg::CFG_BASE_INC) base_r <= cfg_data;
      if (cfg_we && cfg_idx == psv_pkg::CFG_GAIN)     gain_r <= cfg_data[14:0];
    end
  end

  always_ff @(posedge clk) begin
    rot_r  <= rot_nxt;
    nres_r <= nres_nxt;
    sum_r  <= sum_nxt;
    if (in_acc) begin
      mode_r   <= in_ch.mode;
      ev_r.key   <= in_ch.note_key;
      ev_r.ident <= in_ch.note_ident;
      ev_r.chan  <= in_ch.note_channel;
    end
    if (load_out) begin
      if (state_r == ST_EOB) begin
        out_kind_r   <= psv_pkg::KIND_NOTE_END;
        out_sample_r <= '0;
        out_key_r    <= first_v.key;
        out_ident_r  <= first_v.ident;
        out_chan_r   <= first_v.chan;
        out_last_r   <= nlast;
      end else begin
        out_kind_r   <= psv_pkg::KIND_SAMPLE;
        out_sample_r <= sat_sample;
        out_key_r    <= '0;
        out_ident_r  <= '0;
        out_chan_r   <= '0;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.sample      = out_sample_r;
  assign out_ch.end_key     = out_key_r;
  assign out_ch.end_ident   = out_ident_r;
  assign out_ch.end_channel = out_chan_r;
  assign out_ch.last        = out_last_r;
endmodule
`default_nettype wire

/* sv/psv_checker.sv */
// Port-level assertions for the synthesizer and their bind to the top level.
`default_nettype none
module psv_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_kind,
  input wire [17:0] out_sample,
  input wire [7:0]  out_end_key,
  input wire [31:0] out_end_ident,
  input wire [4:0]  out_end_channel,
  input wire        out_last
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_kind))
    else $error("result changed while stalled");

  a_sample_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == psv_pkg::KIND_SAMPLE |-> out_last)
    else $error("audio sample not marked last");

  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == psv_pkg::KIND_SAMPLE |->
      out_end_key == 8'd0 && out_end_ident == 32'd0 && out_end_channel == 5'd0)
    else $error("audio sample carries note fields");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == psv_pkg::KIND_NOTE_END |-> out_sample == 18'd0)
    else $error("note end carries a sample");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind polyphonic_sine_voice_synth psv_checker u_psv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_sample      (out_ch.sample),
  .out_end_key     (out_ch.end_key),
  .out_end_ident   (out_ch.end_ident),
  .out_end_channel (out_ch.end_channel),
  .out_last        (out_ch.last)
);
`default_nettype wire

/* dv/psv_tb_ifc.sv */
// Testbench copies of nothing: interfaces come from the RTL; this file holds shared tb types.
`timescale 1ns / 100ps
package psv_tb_pkg;
  typedef struct packed {
    logic        kind;
    logic [17:0] sample;
    logic [7:0]  end_key;
    logic [31:0] end_ident;
    logic [4:0]  end_channel;
    logic        last;
  } synth_result_t;
endpackage

/* dv/psv_checker.sv */
// Watches the event and result channels, predicts every result and compares.
`timescale 1ns / 100ps
module psv_tb_checker
  import psv_pkg::*;
  import psv_tb_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  psv_in_if          in_ch,
  psv_out_if         out_ch,
  input  wire        cfg_we,
  input  wire        cfg_idx,
  input  wire [31:0] cfg_data,
  output int         fail_count,
  output int         pending_results
);

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] QUARTER_PI2 = 64'd1686629713;

  logic [31:0] base_inc;
  logic [14:0] gain;
  int          nvoices;
  voice_t      voices [MAX_VOICES];
  int          sine_q15 [TABLE_LEN + 1];
  longint unsigned semitone_ratio [12] = '{
    64'd2147483648, 64'd2275179671, 64'd2410468894, 64'd2553802834,
    64'd2705659851, 64'd2866546760, 64'd3037000500, 64'd3217589946,
    64'd3408917802, 64'd3611622603, 64'd3826380858, 64'd4053909304
  };
  longint unsigned divs [5] = '{110, 72, 42, 20, 6};
  synth_result_t expected_results [$];

  initial begin
    longint unsigned x, x2, t, s, v;
    for (int i = 0; i <= TABLE_LEN; i++) begin
      x  = (QUARTER_PI2 * longint'(i)) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int k = 0; k < 5; k++) t = ONE_Q30 - ((x2 * t) >> 30) / divs[k];
      s = (x * t) >> 30;
      v = (s * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      sine_q15[i] = int'(v);
    end
  end

  function automatic int wave_at(logic [31:0] phase);
    logic [1:0] quad;
    int         frac;
    int         mag;
    quad = phase[31:30];
    frac = int'(phase[29 -: SINE_TABLE_BITS]);
    mag  = quad[0] ? sine_q15[TABLE_LEN - frac] : sine_q15[frac];
    return quad[1] ? -mag : mag;
  endfunction

  function automatic logic [31:0] pitch_step(logic [7:0] key);
    int              d, oct, semi;
    longint unsigned prod;
    d    = int'($signed(key)) - 57 + 192;
    oct  = d / 12 - 16;
    semi = d % 12;
    prod = longint'(base_inc) * semitone_ratio[semi];
    return 32'(((prod >> (30 - oct)) + 1) >> 1);
  endfunction

  function automatic bit voice_hit(int i, logic [7:0] k, logic [31:0] id, logic [4:0] ch);
    return (k == 8'hFF || voices[i].key == k) && (id == 32'hFFFFFFFF || voices[i].ident == id)
        && (ch == 5'h1F || voices[i].chan == ch);
  endfunction

  function automatic void drop_voice(int i);
    for (int j = i; j < nvoices - 1; j++) voices[j] = voices[j + 1];
    nvoices--;
  endfunction

  task automatic predict_event(logic [2:0] mode, logic [7:0] k, logic [31:0] id,
                               logic [4:0] ch);
    int            i;
    int            sum;
    int            nends;
    synth_result_t r;
    if (mode <= MODE_CHOKE) begin
      i = 0;
      while (i < nvoices) begin
        if (voice_hit(i, k, id, ch)) begin
          if (mode == MODE_CHOKE) begin
            drop_voice(i);
            continue;
          end
          voices[i].held = 1'b0;
        end
        i++;
      end
      if (mode == MODE_ON && nvoices < MAX_VOICES) begin
        voices[nvoices] = '{held: 1'b1, ident: id, chan: ch, key: k, phase: 32'd0};
        nvoices++;
      end
    end else if (mode == MODE_TICK) begin
      sum = 0;
      for (i = 0; i < nvoices; i++) begin
        if (!voices[i].held) continue;
        sum += ((wave_at(voices[i].phase) * int'(gain) + 1073741824 + 16384) >>> 15) - 32768;
        voices[i].phase += pitch_step(voices[i].key);
      end
      if (sum > 131071) sum = 131071;
      if (sum < -131072) sum = -131072;
      r = '0;
      r.kind   = KIND_SAMPLE;
      r.sample = 18'(sum);
      r.last   = 1'b1;
      expected_results.push_back(r);
    end else if (mode == MODE_EOB) begin
      nends = 0;
      i = 0;
      while (i < nvoices && nends < MAX_RESULTS) begin
        if (!voices[i].held) begin
          r = '0;
          r.kind        = KIND_NOTE_END;
          r.end_key     = voices[i].key;
          r.end_ident   = voices[i].ident;
          r.end_channel = voices[i].chan;
          expected_results.push_back(r);
          nends++;
          drop_voice(i);
          continue;
        end
        i++;
      end
      if (nends > 0) expected_results[$].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    synth_result_t got, want;
    if (!rst_n) begin
      base_inc   = BASE_INC_RST;
      gain       = GAIN_RST;
      nvoices    = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_BASE_INC) base_inc = cfg_data;
        else gain = cfg_data[14:0];
      end
      // results first: a tick transfer here cannot have produced this cycle's output
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.sample, out_ch.end_key, out_ch.end_ident,
                out_ch.end_channel, out_ch.last};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", longint'(got.sample), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
          if (got.sample != want.sample) report_mismatch("sample", got.sample, want.sample);
          if (got.end_key != want.end_key) report_mismatch("end_key", got.end_key, want.end_key);
          if (got.end_ident != want.end_ident)
            report_mismatch("end_ident", got.end_ident, want.end_ident);
          if (got.end_channel != want.end_channel)
            report_mismatch("end_channel", got.end_channel, want.end_channel);
          if (got.last != want.last) report_mismatch("last", got.last, want.last);
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_event(in_ch.mode, in_ch.note_key, in_ch.note_ident, in_ch.note_channel);
    end
    pending_results = expected_results.size();
  end

endmodule

/* dv/testbench.sv */
// Stimulus and verdict for the polyphonic sine voice synthesizer.
`timescale 1ns / 100ps
module testbench;
  import psv_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending_results;
  int          stall_phase;

  psv_in_if  in_ch ();
  psv_out_if out_ch ();

  polyphonic_sine_voice_synth DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  psv_tb_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver stall pattern: bursts of stalls, sometimes long stretches ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase  <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[8]) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_event(logic [2:0] mode, logic [7:0] k, logic [31:0] id,
                            logic [4:0] ch);
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.note_key     <= k;
    in_ch.note_ident   <= id;
    in_ch.note_channel <= ch;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_sender(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'hFF;
    if (r < 4) return 8'(56 + $urandom_range(0, 3));
    return 8'($urandom_range(0, 127));
  endfunction

  // one well-formed phrase: notes on, ticks, some off or choke, sometimes end of block
  task automatic send_phrase();
    logic [7:0]  keys [4];
    logic [31:0] ids [4];
    logic [4:0]  chs [4];
    int          n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      keys[i] = pick_key();
      ids[i]  = ($urandom_range(0, 7) == 0) ? 32'hFFFFFFFF : {1'b0, 31'($urandom)};
      if ($urandom_range(0, 5) == 0) ids[i] = 32'(i);
      chs[i]  = ($urandom_range(0, 7) == 0) ? 5'h1F : 5'($urandom_range(0, 15));
      send_event(MODE_ON, keys[i], ids[i], chs[i]);
    end
    repeat ($urandom_range(1, 4)) send_event(MODE_TICK, '0, '0, '0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: send_event(MODE_OFF, keys[i], ids[i], chs[i]);
        1: send_event(MODE_OFF, 8'hFF, ids[i], 5'h1F);
        2: send_event(MODE_CHOKE, keys[i], 32'hFFFFFFFF, chs[i]);
        default: ;
      endcase
    end
    send_event(MODE_TICK, '0, '0, '0);
    if ($urandom_range(0, 1)) send_event(MODE_EOB, '0, '0, '0);
    if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 20));
  endtask

  task automatic send_noise();
    logic [2:0] m;
    m = 3'($urandom_range(0, 7));
    send_event(m, 8'($urandom), $urandom, 5'($urandom));
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_BASE_INC;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_TICK;
    in_ch.note_key     = '0;
    in_ch.note_ident   = '0;
    in_ch.note_channel = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, extremes of fields, wildcards, full table, unused modes
    send_event(MODE_TICK, '0, '0, '0);
    send_event(MODE_ON, 8'd57, 32'd1, 5'd0);
    send_event(MODE_ON, 8'd127, 32'h7FFFFFFF, 5'd15);
    send_event(MODE_ON, 8'hFF, 32'hFFFFFFFF, 5'h1F);
    send_event(MODE_ON, 8'd0, 32'd0, 5'd3);
    send_event(MODE_TICK, '0, '0, '0);
    send_event(MODE_TICK, '0, '0, '0);
    send_event(MODE_OFF, 8'd57, 32'hFFFFFFFF, 5'h1F);
    send_event(MODE_CHOKE, 8'hFF, 32'hFFFFFFFF, 5'd15);
    send_event(3'd5, 8'hAA, 32'h55555555, 5'h0A);
    send_event(3'd7, 8'h55, 32'hAAAAAAAA, 5'h15);
    send_event(MODE_TICK, '0, '0, '0);
    send_event(MODE_EOB, '0, '0, '0);
    for (int i = 0; i < 18; i++) send_event(MODE_ON, 8'(i * 7), 32'(i), 5'(i));
    send_event(MODE_TICK, '0, '0, '0);
    send_event(MODE_OFF, 8'hFF, 32'hFFFFFFFF, 5'h1F);
    send_event(MODE_EOB, '0, '0, '0);
    send_event(MODE_EOB, '0, '0, '0);
    drain_results();

    // several register settings including extremes
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(CFG_BASE_INC, 32'hFFFFFFFF); write_reg(CFG_GAIN, 32'h7FFF); end
        1: begin write_reg(CFG_BASE_INC, 32'd0); write_reg(CFG_GAIN, 32'd0); end
        2: begin write_reg(CFG_BASE_INC, $urandom); write_reg(CFG_GAIN, $urandom); end
        3: begin write_reg(CFG_BASE_INC, 32'd39370534 << 3);
                 write_reg(CFG_GAIN, 32'h7FFF); end
        default: begin write_reg(CFG_BASE_INC, BASE_INC_RST);
                       write_reg(CFG_GAIN, GAIN_RST); end
      endcase
      // several loud voices to reach saturation
      if (phase == 0) begin
        for (int i = 0; i < 8; i++) send_event(MODE_ON, 8'(57 + 12 * (i % 2)), 32'd100, 5'd1);
        repeat (6) send_event(MODE_TICK, '0, '0, '0);
        send_event(MODE_OFF, 8'hFF, 32'd100, 5'd1);
        send_event(MODE_EOB, '0, '0, '0);
      end
      repeat (2) send_phrase();
      repeat (3) send_noise();
      send_event(MODE_OFF, 8'hFF, 32'hFFFFFFFF, 5'h1F);
      send_event(MODE_EOB, '0, '0, '0);
      drain_results();
    end

    send_event(MODE_OFF, 8'hFF, 32'hFFFFFFFF, 5'h1F);
    send_event(MODE_EOB, '0, '0, '0);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
